[hw/rtl/rlbs_pkg.sv]
// ----------------------------------------------------------------------------
// rlbs_pkg
// Types, codes and color schedule tables for the RGB LED blink/soft-PWM core.
// ----------------------------------------------------------------------------
package rlbs_pkg;

   // request codes
   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_SET   = 3'd1;
   localparam logic [2:0] REQ_BLINK = 3'd2;
   localparam logic [2:0] REQ_OFF   = 3'd3;
   localparam logic [2:0] REQ_MODE  = 3'd4;

   // light modes
   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_ON    = 2'd1;
   localparam logic [1:0] MODE_TIMED = 2'd2;

   // colors
   localparam logic [2:0] COL_OFF    = 3'd0;
   localparam logic [2:0] COL_RED    = 3'd1;
   localparam logic [2:0] COL_GREEN  = 3'd2;
   localparam logic [2:0] COL_BLUE   = 3'd3;
   localparam logic [2:0] COL_WHITE  = 3'd4;
   localparam logic [2:0] COL_VIOLET = 3'd5;
   localparam logic [2:0] COL_CYAN   = 3'd6;
   localparam logic [2:0] COL_YELLOW = 3'd7;

   // lamp bits
   localparam logic [2:0] LAMP_R    = 3'b001;
   localparam logic [2:0] LAMP_G    = 3'b010;
   localparam logic [2:0] LAMP_B    = 3'b100;
   localparam logic [2:0] LAMP_DARK = 3'b000;

   // CSR indexes
   localparam logic [1:0] CSR_ACTIVE_HIGH  = 2'd0;
   localparam logic [1:0] CSR_EXPIRY_TICKS = 2'd1;

   localparam int unsigned AGE_W      = 27;
   localparam int unsigned PHASE_W    = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam logic [AGE_W-1:0]   EXPIRY_DEFAULT = 27'd86400000;
   localparam logic [AGE_W-1:0]   AGE_MAX        = '1;
   localparam logic [PHASE_W-1:0] PHASE_MAX      = '1;

   // slot schedules, padded to 8 entries (pad entries are never reached)
   localparam logic [2:0] SCHED_WHITE [8] = '{LAMP_R, LAMP_R, LAMP_R, LAMP_G,
                                             LAMP_B, LAMP_B, LAMP_B, LAMP_DARK};
   localparam logic [2:0] SCHED_VIOLET [8] = '{LAMP_R, LAMP_R, LAMP_B, LAMP_B,
                                              LAMP_DARK, LAMP_DARK, LAMP_DARK, LAMP_DARK};
   localparam logic [2:0] SCHED_CYAN [8] = '{LAMP_G, LAMP_B, LAMP_B, LAMP_B,
                                            LAMP_DARK, LAMP_DARK, LAMP_DARK, LAMP_DARK};
   localparam logic [2:0] SCHED_YELLOW [8] = '{LAMP_R, LAMP_G, LAMP_G, LAMP_DARK,
                                              LAMP_R, LAMP_DARK, LAMP_DARK, LAMP_DARK};

   typedef struct packed {
      logic [2:0]  req_type;
      logic [2:0]  colour;
      logic        forced;
      logic [7:0]  repeat_count;
      logic [15:0] lit_ms;
      logic [15:0] dark_ms;
      logic [1:0]  new_mode;
   } req_payload_type;

   typedef struct packed {
      logic       red_pin;
      logic       green_pin;
      logic       blue_pin;
      logic       blink_finished;
      logic [1:0] mode_now;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0] colour;   // 0 or a composite color
      logic [2:0] slot;
      logic [2:0] lamp;     // bit0 red, bit1 green, bit2 blue
   } pwm_type;

   typedef struct packed {
      logic [1:0]         light_mode;
      logic [AGE_W-1:0]   mode_age;
      logic               blink_active;
      logic [2:0]         blink_colour;
      logic [7:0]         blink_target;
      logic [7:0]         blinks_done;
      logic [15:0]        lit_len;
      logic [15:0]        dark_len;
      logic [PHASE_W-1:0] phase_age;
      logic               phase_lit;
      logic               blink_forced;
      pwm_type            pwm;
   } state_type;

   localparam state_type STATE_RESET = '{
      light_mode:   MODE_TIMED,
      mode_age:     '0,
      blink_active: 1'b0,
      blink_colour: COL_OFF,
      blink_target: '0,
      blinks_done:  '0,
      lit_len:      '0,
      dark_len:     '0,
      phase_age:    '0,
      phase_lit:    1'b0,
      blink_forced: 1'b0,
      pwm:          '{colour: COL_OFF, slot: 3'd0, lamp: LAMP_DARK}
   };

   // schedule length, 0 for colors without a schedule
   function automatic logic [3:0] sched_len(logic [2:0] c);
      logic [3:0] len;
      case (c)
         COL_WHITE:  len = 4'd8;
         COL_VIOLET: len = 4'd4;
         COL_CYAN:   len = 4'd4;
         COL_YELLOW: len = 4'd5;
         default:    len = 4'd0;
      endcase
      return len;
   endfunction

   function automatic logic [2:0] sched_lamp(logic [2:0] c, logic [2:0] slot);
      logic [2:0] lamp;
      case (c)
         COL_WHITE:  lamp = SCHED_WHITE[slot];
         COL_VIOLET: lamp = SCHED_VIOLET[slot];
         COL_CYAN:   lamp = SCHED_CYAN[slot];
         COL_YELLOW: lamp = SCHED_YELLOW[slot];
         default:    lamp = LAMP_DARK;
      endcase
      return lamp;
   endfunction

   // load a color: composites restart their schedule, plain colors keep slot
   function automatic pwm_type apply_colour(pwm_type cur, logic [2:0] c);
      pwm_type res;
      res = cur;
      if (sched_len(c) != 4'd0) begin
         res.colour = c;
         res.slot   = 3'd0;
         res.lamp   = sched_lamp(c, 3'd0);
      end else begin
         res.colour = COL_OFF;
         case (c)
            COL_RED:   res.lamp = LAMP_R;
            COL_GREEN: res.lamp = LAMP_G;
            COL_BLUE:  res.lamp = LAMP_B;
            default:   res.lamp = LAMP_DARK;
         endcase
      end
      return res;
   endfunction

endpackage

[hw/rtl/rlbs_step.sv]
// ----------------------------------------------------------------------------
// rlbs_step
// Next-state and result logic for one request against the current state.
// ----------------------------------------------------------------------------
module rlbs_step (
   input  rlbs_pkg::state_type       cur,
   input  rlbs_pkg::req_payload_type item,
   input  logic                      active_high,
   input  logic [rlbs_pkg::AGE_W-1:0] expiry_ticks,
   output rlbs_pkg::state_type       nxt,
   output rlbs_pkg::rsp_payload_type result
);
   import rlbs_pkg::*;

   logic [3:0] len;
   logic [3:0] slot_sum;
   logic       same_blink;
   logic [2:0] pins;

   assign len = sched_len(cur.pwm.colour);

   assign same_blink = cur.blink_active && (cur.blink_colour == item.colour) &&
                       (cur.blink_target == item.repeat_count) &&
                       (cur.lit_len == item.lit_ms) && (cur.dark_len == item.dark_ms);

   always_comb begin
      nxt      = cur;
      slot_sum = {1'b0, cur.pwm.slot} + 4'd1;
      if (slot_sum >= len) begin
         slot_sum = slot_sum - len;
      end
      case (item.req_type)
         REQ_TICK: begin
            if (nxt.mode_age != AGE_MAX) begin
               nxt.mode_age = nxt.mode_age + 1'b1;
            end
            if (nxt.light_mode == MODE_TIMED && nxt.mode_age > expiry_ticks) begin
               nxt.light_mode = MODE_OFF;
            end
            // soft-PWM steps before the blink timer
            if (nxt.pwm.colour != COL_OFF) begin
               if (len == 4'd0) begin
                  nxt.pwm.colour = COL_OFF;
               end else begin
                  nxt.pwm.slot = slot_sum[2:0];
                  nxt.pwm.lamp = sched_lamp(nxt.pwm.colour, slot_sum[2:0]);
               end
            end
            if (nxt.blink_active) begin
               if (!nxt.blink_forced && nxt.light_mode == MODE_OFF) begin
                  nxt.blink_active = 1'b0;
                  nxt.pwm          = apply_colour(nxt.pwm, COL_OFF);
               end else begin
                  if (nxt.phase_age != PHASE_MAX) begin
                     nxt.phase_age = nxt.phase_age + 1'b1;
                  end
                  if (nxt.phase_lit) begin
                     if (nxt.phase_age >= nxt.lit_len) begin
                        nxt.pwm         = apply_colour(nxt.pwm, COL_OFF);
                        nxt.phase_lit   = 1'b0;
                        nxt.phase_age   = '0;
                        nxt.blinks_done = nxt.blinks_done + 8'd1;
                        if (nxt.blink_target != 8'd0 &&
                            nxt.blinks_done >= nxt.blink_target) begin
                           nxt.blink_active = 1'b0;
                        end
                     end
                  end else if (nxt.phase_age >= nxt.dark_len) begin
                     nxt.pwm       = apply_colour(nxt.pwm, nxt.blink_colour);
                     nxt.phase_lit = 1'b1;
                     nxt.phase_age = '0;
                  end
               end
            end
         end
         REQ_SET: begin
            nxt.blink_active = 1'b0;
            // the mode gate is only consulted (and may expire) when not forced
            if (!item.forced && nxt.light_mode == MODE_TIMED &&
                nxt.mode_age > expiry_ticks) begin
               nxt.light_mode = MODE_OFF;
            end
            if (item.forced || nxt.light_mode != MODE_OFF) begin
               nxt.pwm = apply_colour(nxt.pwm, item.colour);
            end
         end
         REQ_BLINK: begin
            if (!item.forced && nxt.light_mode == MODE_TIMED &&
                nxt.mode_age > expiry_ticks) begin
               nxt.light_mode = MODE_OFF;
            end
            if (!item.forced && nxt.light_mode == MODE_OFF) begin
               nxt.blink_active = 1'b0;
            end else begin
               nxt.blink_forced = item.forced;
               if (!same_blink) begin
                  nxt.blink_colour = item.colour;
                  nxt.blink_target = item.repeat_count;
                  nxt.blinks_done  = '0;
                  nxt.lit_len      = item.lit_ms;
                  nxt.dark_len     = item.dark_ms;
                  nxt.phase_age    = '0;
                  nxt.phase_lit    = 1'b1;
                  nxt.blink_active = 1'b1;
                  nxt.pwm          = apply_colour(nxt.pwm, item.colour);
               end
            end
         end
         REQ_OFF: begin
            nxt.blink_active = 1'b0;
            nxt.pwm          = apply_colour(nxt.pwm, COL_OFF);
         end
         REQ_MODE: begin
            if (item.new_mode == MODE_OFF || item.new_mode == MODE_ON ||
                item.new_mode == MODE_TIMED) begin
               nxt.light_mode = item.new_mode;
               nxt.mode_age   = '0;
               if (item.new_mode == MODE_OFF) begin
                  nxt.blink_active = 1'b0;
                  nxt.pwm          = apply_colour(nxt.pwm, COL_OFF);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign pins = active_high ? nxt.pwm.lamp : ~nxt.pwm.lamp;

   assign result.red_pin        = pins[0];
   assign result.green_pin      = pins[1];
   assign result.blue_pin       = pins[2];
   assign result.blink_finished = ~nxt.blink_active;
   assign result.mode_now       = nxt.light_mode;

endmodule

[hw/rtl/rgb_led_blink_softpwm_core.sv]
// ----------------------------------------------------------------------------
// rgb_led_blink_softpwm_core
// RGB LED controller: mode gate, blink sequencer and soft-PWM color mixing.
// ----------------------------------------------------------------------------
//  channel | ports                       | carries
//  --------+-----------------------------+---------------------------------
//  request | req_valid/req_ready/req_data | tick or command, one per transfer
//  result  | rsp_valid/rsp_ready/rsp_data | pins, done flag, mode per request
//  csr     | csr_we/csr_index/csr_wdata   | polarity and timed-mode expiry
//
//  One request per clock sustained while rsp_ready stays high; the result
//  passes the input register, then the state and result register.
//  The state update is a single pass of rlbs_step between the two registers.
//  A stalled result holds; the input register keeps taking one more request.
//  Synchronous reset clears the state to timed mode, lamp dark, no blink.
// ----------------------------------------------------------------------------
module rgb_led_blink_softpwm_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  rlbs_pkg::req_payload_type       req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rlbs_pkg::rsp_payload_type       rsp_data,
   input  logic                            csr_we,
   input  logic [rlbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rlbs_pkg::AGE_W-1:0]      csr_wdata
);
   import rlbs_pkg::*;

   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   state_type       state_ff;
   state_type       state_in;
   rsp_payload_type result_in;
   logic            active_high_ff;
   logic [AGE_W-1:0] expiry_ff;
   logic            advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   rlbs_step u_step (
      .cur          (state_ff),
      .item         (in_data_ff),
      .active_high  (active_high_ff),
      .expiry_ticks (expiry_ff),
      .nxt          (state_in),
      .result       (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_high_ff <= 1'b0;
         expiry_ff      <= EXPIRY_DEFAULT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE_HIGH:  active_high_ff <= csr_wdata[0];
            CSR_EXPIRY_TICKS: expiry_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

[hw/rtl/rlbs_checker.sv]
// ----------------------------------------------------------------------------
// rlbs_checker
// Port-level checks for the RGB LED core, bound to the top level.
// ----------------------------------------------------------------------------
module rlbs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input rlbs_pkg::rsp_payload_type rsp_data
);
   import rlbs_pkg::*;

   // requests transferred but whose result has not yet been taken
   logic [1:0] pending_ff;
   logic [1:0] pending_in;

   always_comb begin
      pending_in = pending_ff;
      if (req_valid && req_ready) begin
         pending_in = pending_in + 2'd1;
      end
      if (rsp_valid && rsp_ready) begin
         pending_in = pending_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_invented_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result without a pending request");

   a_buffer_full: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd2 && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken with both stages full and stalled");

endmodule

bind rgb_led_blink_softpwm_core rlbs_checker u_rlbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[tb/rgb_led_blink_softpwm_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_blink_softpwm_core_test
// Self-checking bench for the RGB LED blink and soft-PWM core. Requests (ticks
// and commands) go in over a valid/ready channel. A lamp predictor follows the
// mode gate, the blink sequencer and the color slot schedules, and every
// result transfer is compared field by field with the oldest prediction.
// Phases change polarity and timed-mode expiry and vary the idling on both
// channels.
// ----------------------------------------------------------------------------
module rgb_led_blink_softpwm_core_test;
   import rlbs_pkg::*;

   localparam int CLOCK_HALF      = 10;
   localparam int RESET_CYCLES    = 9;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int LONG_HOLD       = 60;
   localparam int SETTLE_CYCLES   = 4;
   localparam int CYCLE_LIMIT     = 100000;
   localparam int PRINT_LIMIT     = 100;

   localparam logic [1:0] MODE_UNUSED      = 2'd3;
   localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_style_type;

   // ------------------------------------------------------------------------
   // lamp predictor and result store
   // ------------------------------------------------------------------------
   class lamp_scoreboard;
      bit               polarity_high;
      bit [AGE_W-1:0]   expiry;
      bit [1:0]         mode;
      bit [AGE_W-1:0]   mode_ticks;
      bit               blinking;
      bit               blink_forced;
      bit [2:0]         blink_col;
      bit [7:0]         blink_goal;
      bit [7:0]         blinks_seen;
      bit [15:0]        on_len;
      bit [15:0]        off_len;
      bit [PHASE_W-1:0] phase_ticks;
      bit               in_lit;
      bit [2:0]         mix_col;
      bit [2:0]         mix_slot;
      bit [2:0]         lamp;
      rsp_payload_type  expected_pins[$];
      int               error_count;

      function new();
         expiry      = EXPIRY_DEFAULT;
         mode        = MODE_TIMED;
         error_count = 0;
      endfunction

      function void set_config(bit pol, bit [AGE_W-1:0] exp_ticks);
         polarity_high = pol;
         expiry        = exp_ticks;
      endfunction

      function int mix_len(bit [2:0] c);
         case (c)
            COL_WHITE:  return 8;
            COL_VIOLET: return 4;
            COL_CYAN:   return 4;
            COL_YELLOW: return 5;
            default:    return 0;
         endcase
      endfunction

      function bit [2:0] mix_lamp(bit [2:0] c, bit [2:0] s);
         case (c)
            COL_WHITE:  return (s < 3) ? LAMP_R : (s == 3) ? LAMP_G :
                               (s < 7) ? LAMP_B : LAMP_DARK;
            COL_VIOLET: return (s < 2) ? LAMP_R : LAMP_B;
            COL_CYAN:   return (s == 0) ? LAMP_G : LAMP_B;
            COL_YELLOW: return (s == 0 || s == 4) ? LAMP_R :
                               (s == 3) ? LAMP_DARK : LAMP_G;
            default:    return LAMP_DARK;
         endcase
      endfunction

      // composites restart their schedule; plain colors light one channel
      function void paint(bit [2:0] c);
         if (mix_len(c) != 0) begin
            mix_col  = c;
            mix_slot = 3'd0;
            lamp     = mix_lamp(c, 3'd0);
         end else begin
            mix_col = COL_OFF;
            case (c)
               COL_RED:   lamp = LAMP_R;
               COL_GREEN: lamp = LAMP_G;
               COL_BLUE:  lamp = LAMP_B;
               default:   lamp = LAMP_DARK;
            endcase
         end
      endfunction

      // checking the gate also drops an expired timed mode to off
      function bit gate_open();
         if (mode == MODE_OFF)
            return 1'b0;
         if (mode == MODE_TIMED && mode_ticks > expiry) begin
            mode = MODE_OFF;
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void advance_mix();
         int next_slot;
         if (mix_col == COL_OFF)
            return;
         next_slot = (int'(mix_slot) + 1) % mix_len(mix_col);
         mix_slot  = next_slot[2:0];
         lamp      = mix_lamp(mix_col, mix_slot);
      endfunction

      function void advance_blink();
         if (!blinking)
            return;
         if (!blink_forced && !gate_open()) begin
            blinking = 1'b0;
            paint(COL_OFF);
            return;
         end
         if (phase_ticks != PHASE_MAX)
            phase_ticks++;
         if (in_lit) begin
            if (phase_ticks >= on_len) begin
               paint(COL_OFF);
               in_lit      = 1'b0;
               phase_ticks = '0;
               blinks_seen = blinks_seen + 8'd1;
               if (blink_goal != 0 && blinks_seen >= blink_goal)
                  blinking = 1'b0;
            end
         end else if (phase_ticks >= off_len) begin
            paint(blink_col);
            in_lit      = 1'b1;
            phase_ticks = '0;
         end
      endfunction

      function void tick();
         if (mode_ticks != AGE_MAX)
            mode_ticks++;
         if (mode == MODE_TIMED && mode_ticks > expiry)
            mode = MODE_OFF;
         advance_mix();
         advance_blink();
      endfunction

      function void start_blink(req_payload_type r);
         if (!r.forced && !gate_open()) begin
            blinking = 1'b0;
            return;
         end
         blink_forced = r.forced;
         // same sequence already running: only the forced flag changes
         if (blinking && blink_col == r.colour && blink_goal == r.repeat_count &&
             on_len == r.lit_ms && off_len == r.dark_ms)
            return;
         blink_col   = r.colour;
         blink_goal  = r.repeat_count;
         blinks_seen = '0;
         on_len      = r.lit_ms;
         off_len     = r.dark_ms;
         phase_ticks = '0;
         in_lit      = 1'b1;
         blinking    = 1'b1;
         paint(r.colour);
      endfunction

      function void note_request(req_payload_type r);
         rsp_payload_type e;
         bit [2:0]        pins;
         case (r.req_type)
            REQ_TICK:  tick();
            REQ_SET: begin
               blinking = 1'b0;
               if (r.forced || gate_open())
                  paint(r.colour);
            end
            REQ_BLINK: start_blink(r);
            REQ_OFF: begin
               blinking = 1'b0;
               paint(COL_OFF);
            end
            REQ_MODE: begin
               if (r.new_mode <= MODE_TIMED) begin
                  mode       = r.new_mode;
                  mode_ticks = '0;
                  if (r.new_mode == MODE_OFF) begin
                     blinking = 1'b0;
                     paint(COL_OFF);
                  end
               end
            end
            default: ;
         endcase
         pins             = polarity_high ? lamp : ~lamp;
         e.red_pin        = pins[0];
         e.green_pin      = pins[1];
         e.blue_pin       = pins[2];
         e.blink_finished = !blinking;
         e.mode_now       = mode;
         expected_pins.push_back(e);
      endfunction

      function int pending();
         return expected_pins.size();
      endfunction

      task report(string msg);
         error_count++;
         if (error_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task compare_field(string name, int got, int want);
         if (got != want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_pins.size() == 0) begin
            report($sformatf("result %b with nothing outstanding", got));
            return;
         end
         want = expected_pins.pop_front();
         compare_field("red_pin", got.red_pin, want.red_pin);
         compare_field("green_pin", got.green_pin, want.green_pin);
         compare_field("blue_pin", got.blue_pin, want.blue_pin);
         compare_field("blink_finished", got.blink_finished, want.blink_finished);
         compare_field("mode_now", got.mode_now, want.mode_now);
      endtask

      task flag_leftovers();
         if (expected_pins.size() != 0)
            report($sformatf("%0d results never arrived", expected_pins.size()));
      endtask
   endclass

   // ------------------------------------------------------------------------
   // signals and DUT
   // ------------------------------------------------------------------------
   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_payload_type      req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_payload_type      rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [AGE_W-1:0]     csr_wdata = '0;

   lamp_scoreboard  product;
   int              sender_idle_pct    = 0;
   int              receiver_stall_pct = 0;
   int              hold_token         = 0;
   int              hold_seen          = 0;
   int              hold_left          = 0;
   int              cycle_count        = 0;
   req_payload_type last_blink         = '0;
   bit              have_blink         = 1'b0;

   bit             cfg_polarity [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0,
                                             1'b1, 1'b0, 1'b1, 1'b0};
   bit [AGE_W-1:0] cfg_expiry   [PHASES] = '{27'd0, 27'd1, 27'd5, 27'd20,
                                             27'h7FFFFFF, EXPIRY_DEFAULT,
                                             27'd3, 27'd60};

   rgb_led_blink_softpwm_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #(CLOCK_HALF);
      clock = 1'b1;
      #(CLOCK_HALF);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[rgb_led_blink_softpwm_core] ERROR");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold on request
   always @(negedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         product.check_result(rsp_data);
   end

   // ------------------------------------------------------------------------
   // drivers (entered and left just after a falling edge)
   // ------------------------------------------------------------------------
   task automatic send_item(req_payload_type item);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (!req_ready);
      product.note_request(item);
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (product.pending() != 0)
         @(negedge clock);
   endtask

   task automatic write_config(bit polarity, bit [AGE_W-1:0] expiry_value);
      csr_we    <= 1'b1;
      csr_index <= CSR_ACTIVE_HIGH;
      csr_wdata <= AGE_W'(polarity);
      @(negedge clock);
      csr_index <= CSR_EXPIRY_TICKS;
      csr_wdata <= expiry_value;
      @(negedge clock);
      csr_we <= 1'b0;
      product.set_config(polarity, expiry_value);
   endtask

   task automatic set_idling(idle_style_type style);
      case (style)
         IDLE_NONE:     begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         IDLE_SENDER:   begin sender_idle_pct = 69; receiver_stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 69; end
         default:       begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase
   endtask

   function automatic req_payload_type make_req(logic [2:0] kind, logic [2:0] col,
                                                logic frc, logic [7:0] count,
                                                logic [15:0] on_t, logic [15:0] off_t,
                                                logic [1:0] m);
      req_payload_type r;
      r.req_type     = kind;
      r.colour       = col;
      r.forced       = frc;
      r.repeat_count = count;
      r.lit_ms       = on_t;
      r.dark_ms      = off_t;
      r.new_mode     = m;
      return r;
   endfunction

   // mostly ticks; blinks mostly use short phases and small counts (0 blinks forever)
   function automatic req_payload_type random_request();
      req_payload_type r;
      int              pick;
      r.req_type     = REQ_TICK;
      r.colour       = 3'($urandom);
      r.forced       = 1'($urandom);
      r.repeat_count = 8'($urandom);
      r.lit_ms       = 16'($urandom);
      r.dark_ms      = 16'($urandom);
      r.new_mode     = 2'($urandom);
      pick = $urandom_range(99, 0);
      if (pick < 55) begin
         r.req_type = REQ_TICK;
      end else if (pick < 65) begin
         r.req_type = REQ_SET;
      end else if (pick < 82) begin
         r.req_type = REQ_BLINK;
         if (have_blink && $urandom_range(3, 0) == 0) begin
            r.colour       = last_blink.colour;
            r.repeat_count = last_blink.repeat_count;
            r.lit_ms       = last_blink.lit_ms;
            r.dark_ms      = last_blink.dark_ms;
         end else begin
            if ($urandom_range(9, 0) != 0)
               r.repeat_count = 8'($urandom_range(4, 0));
            if ($urandom_range(9, 0) != 0)
               r.lit_ms = 16'($urandom_range(6, 0));
            if ($urandom_range(9, 0) != 0)
               r.dark_ms = 16'($urandom_range(6, 0));
         end
         r.forced   = ($urandom_range(3, 0) == 0);
         last_blink = r;
         have_blink = 1'b1;
      end else if (pick < 87) begin
         r.req_type = REQ_OFF;
      end else if (pick < 97) begin
         r.req_type = REQ_MODE;
         if ($urandom_range(9, 0) != 0)
            r.new_mode = 2'($urandom_range(2, 0));
      end else begin
         r.req_type = 3'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST));
      end
      return r;
   endfunction

   // runs with zero expiry and active-high polarity
   task automatic run_directed();
      int k;
      send_item(make_req(REQ_UNUSED_FIRST, COL_YELLOW, 1'b1, 8'hFF, 16'hFFFF,
                         16'hFFFF, MODE_UNUSED));
      send_item(make_req(REQ_UNUSED_LAST, COL_OFF, 1'b0, 8'h00, 16'h0000,
                         16'h0000, MODE_OFF));
      send_item(make_req(REQ_MODE, COL_OFF, 1'b0, 8'h00, 16'h0000, 16'h0000,
                         MODE_UNUSED));
      // zero expiry: timed mode dies on the first tick
      send_item(make_req(REQ_TICK, COL_OFF, 1'b0, 8'h00, 16'h0000, 16'h0000, MODE_OFF));
      send_item(make_req(REQ_SET, COL_RED, 1'b0, 8'h00, 16'h0000, 16'h0000, MODE_OFF));
      send_item(make_req(REQ_SET, COL_GREEN, 1'b1, 8'h00, 16'h0000, 16'h0000, MODE_OFF));
      send_item(make_req(REQ_BLINK, COL_WHITE, 1'b1, 8'd2, 16'd1, 16'd1, MODE_OFF));
      // identical blink, now unforced: the closed gate stops it
      send_item(make_req(REQ_BLINK, COL_WHITE, 1'b0, 8'd2, 16'd1, 16'd1, MODE_OFF));
      send_item(make_req(REQ_TICK, COL_OFF, 1'b0, 8'h00, 16'h0000, 16'h0000, MODE_OFF));
      send_item(make_req(REQ_MODE, COL_OFF, 1'b0, 8'h00, 16'h0000, 16'h0000, MODE_ON));
      send_item(make_req(REQ_BLINK, COL_VIOLET, 1'b0, 8'd1, 16'd0, 16'd0, MODE_OFF));
      for (k = 0; k < 3; k++)
         send_item(make_req(REQ_TICK, COL_OFF, 1'b0, 8'h00, 16'h0000, 16'h0000, MODE_OFF));
      send_item(make_req(REQ_BLINK, COL_CYAN, 1'b0, 8'd0, 16'd2, 16'd1, MODE_OFF));
      for (k = 0; k < 3; k++)
         send_item(make_req(REQ_TICK, COL_OFF, 1'b0, 8'h00, 16'h0000, 16'h0000, MODE_OFF));
      send_item(make_req(REQ_SET, COL_YELLOW, 1'b0, 8'h00, 16'h0000, 16'h0000, MODE_OFF));
      for (k = 0; k < 3; k++)
         send_item(make_req(REQ_TICK, COL_OFF, 1'b0, 8'h00, 16'h0000, 16'h0000, MODE_OFF));
      send_item(make_req(REQ_OFF, COL_BLUE, 1'b1, 8'h00, 16'h0000, 16'h0000, MODE_OFF));
      send_item(make_req(REQ_MODE, COL_OFF, 1'b0, 8'h00, 16'h0000, 16'h0000, MODE_TIMED));
      send_item(make_req(REQ_BLINK, COL_YELLOW, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF,
                         MODE_OFF));
      send_item(make_req(REQ_TICK, COL_OFF, 1'b0, 8'h00, 16'h0000, 16'h0000, MODE_OFF));
      send_item(make_req(REQ_MODE, COL_OFF, 1'b0, 8'h00, 16'h0000, 16'h0000, MODE_OFF));
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      int phase;
      int n;
      product = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            stop_sending();
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge clock);
         end
         write_config(cfg_polarity[phase], cfg_expiry[phase]);
         set_idling(idle_style_type'(phase % 4));
         if (phase == 0)
            run_directed();
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long result back-pressure while requests keep coming
            if (phase == 2 && n == 10)
               hold_token++;
            if (phase == 5 && n == 25) begin
               stop_sending();
               wait_drained();
            end
            send_item(random_request());
         end
      end
      stop_sending();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      product.flag_leftovers();
      if (product.error_count == 0)
         $display("[rgb_led_blink_softpwm_core] OK");
      else
         $display("[rgb_led_blink_softpwm_core] ERROR");
      $finish;
   end

endmodule
